// ===== src/ecal_pkg.sv =====
// Package for the epoch seconds to calendar converter.
// Holds widths, calendar constants, the shared compare-subtract types and small tables.
// No dependencies.
package ecal_pkg;

  localparam int EPOCH_W  = 33;
  localparam int ZONE_W   = 17;
  localparam int SUM_W    = 34;
  localparam int T_W      = 32;
  localparam int DAY_Q_W  = 16;
  localparam int HOUR_Q_W = 5;
  localparam int MIN_Q_W  = 6;
  localparam int BLK_Q_W  = 6;
  localparam int STEP_W   = 4;

  localparam logic [T_W-1:0] LAST_SECOND = 32'd4102444799;
  localparam logic [T_W-1:0] DAY_SECS    = 32'd86400;
  localparam logic [T_W-1:0] HOUR_SECS   = 32'd3600;
  localparam logic [T_W-1:0] MIN_SECS    = 32'd60;
  localparam logic [T_W-1:0] BLOCK_DAYS  = 32'd1461;
  localparam logic [T_W-1:0] YEAR_DAYS   = 32'd365;

  localparam logic signed [ZONE_W-1:0] ZONE_RESET = 17'sd28800;
  localparam logic [7:0] EPOCH_YEAR    = 8'd70;
  localparam logic [2:0] EPOCH_WEEKDAY = 3'd4;
  localparam logic [3:0] WEEK_DAYS     = 4'd7;
  localparam logic [3:0] MONTH_JAN     = 4'd0;
  localparam logic [3:0] MONTH_FEB     = 4'd1;
  localparam logic [3:0] MONTH_DEC     = 4'd11;

  localparam logic [4:0] MONTH_DAYS [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  // 2^k mod 7 for each bit weight of the day count
  localparam logic [2:0] POW2_MOD7 [16] = '{
    3'd1, 3'd2, 3'd4, 3'd1, 3'd2, 3'd4, 3'd1, 3'd2,
    3'd4, 3'd1, 3'd2, 3'd4, 3'd1, 3'd2, 3'd4, 3'd1
  };

  typedef struct packed {
    logic [T_W-1:0] a;
    logic [T_W-1:0] b;
  } operand_t;

  typedef struct packed {
    logic           ge;
    logic [T_W-1:0] diff;
  } csub_res_t;

  function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    len = MONTH_DAYS[month];
    if (month == MONTH_FEB && leap) begin
      len = len + 5'd1;
    end
    return len;
  endfunction

endpackage

// ===== src/ecal_ifs.sv =====
// Channel interfaces of the calendar converter: input seconds and output calendar item.
// Depends on ecal_pkg.
interface ecal_secs_if;
  import ecal_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [EPOCH_W-1:0] epoch_seconds;
  modport source (output valid, output epoch_seconds, input ready);
  modport sink (input valid, input epoch_seconds, output ready);
endinterface

interface ecal_cal_if;
  logic       valid;
  logic       ready;
  logic [5:0] second;
  logic [5:0] minute;
  logic [4:0] hour;
  logic [4:0] day_of_month;
  logic [3:0] month;
  logic [7:0] year_since_1900;
  logic [2:0] weekday;
  logic [8:0] day_of_year;
  logic       clamped;
  modport source (output valid, output second, output minute, output hour,
                  output day_of_month, output month, output year_since_1900,
                  output weekday, output day_of_year, output clamped, input ready);
  modport sink (input valid, input second, input minute, input hour,
                input day_of_month, input month, input year_since_1900,
                input weekday, input day_of_year, input clamped, output ready);
endinterface

// ===== src/epoch_seconds_to_calendar.sv =====
// Epoch seconds to local calendar time.
// Channels: secs (valid/ready, epoch_seconds, signed seconds since 1970 UTC) in,
// cal (valid/ready, second .. day_of_year and clamped) out. An item moves at a
// rising edge with valid and ready both high.
// Config: wr_en/wr_data write the signed zone offset added to every input;
// write it only while the block is idle. Reset loads an offset of eight hours.
// The sum is clamped to 1970-01-01 00:00:00 below and 2099-12-31 23:59:59 above,
// and the clamped flag marks it.
// The single compare-subtract unit runs 16 + 5 + 6 + 6 restoring division
// steps for each item, then up to 4 year steps and up to 12 month steps.
// One item is in work at a time; secs.ready is high only while idle.
// A result waiting on a stalled receiver does not stop the next item from being
// accepted; that item holds in its last step until the output register frees up.
// Reset empties the output register and returns the sequencer to idle.
// Depends on ecal_pkg, ecal_ifs, ecal_csub and ecal_seq.
module epoch_seconds_to_calendar (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               wr_en,
  input  logic signed [ecal_pkg::ZONE_W-1:0] wr_data,
  ecal_secs_if.sink                          secs,
  ecal_cal_if.source                         cal
);
  import ecal_pkg::*;

  logic signed [ZONE_W-1:0] zone_offset;
  operand_t                 op;
  csub_res_t                res;

  always_ff @(posedge clk) begin
    if (rst) begin
      zone_offset <= ZONE_RESET;
    end else if (wr_en) begin
      zone_offset <= wr_data;
    end
  end

  ecal_csub u_csub (
    .op  (op),
    .res (res)
  );

  ecal_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .zone_offset (zone_offset),
    .secs        (secs),
    .cal         (cal),
    .op          (op),
    .res         (res)
  );

`ifndef ASSERT_OFF
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    secs.valid && secs.ready |=> !secs.ready)
    else $error("input taken again before the item was finished");

  a_time_range: assert property (@(posedge clk) disable iff (rst)
    cal.valid |-> cal.second < 6'd60 && cal.minute < 6'd60 && cal.hour < 5'd24)
    else $error("time of day out of range");

  a_date_range: assert property (@(posedge clk) disable iff (rst)
    cal.valid |-> cal.month <= MONTH_DEC && cal.day_of_month != 5'd0 &&
                  cal.weekday < 3'd7 && cal.day_of_year <= 9'd365 &&
                  cal.year_since_1900 >= EPOCH_YEAR && cal.year_since_1900 <= 8'd199)
    else $error("calendar date out of range");
`endif

endmodule

// ===== src/ecal_csub.sv =====
// Shared compare-subtract unit: a >= b flag and a - b, used for every division
// step and every year and month walk. Depends on ecal_pkg.
module ecal_csub (
  input  ecal_pkg::operand_t  op,
  output ecal_pkg::csub_res_t res
);
  import ecal_pkg::*;

  logic [T_W:0] wide;

  assign wide     = {1'b0, op.a} - {1'b0, op.b};
  assign res.ge   = ~wide[T_W];
  assign res.diff = wide[T_W-1:0];

endmodule

// ===== src/ecal_seq.sv =====
// Sequencer of the calendar converter: clamp, restoring divisions, year and month
// walks on the shared compare-subtract unit, and the output register.
// Depends on ecal_pkg and ecal_ifs.
module ecal_seq (
  input  logic                              clk,
  input  logic                              rst,
  input  logic signed [ecal_pkg::ZONE_W-1:0] zone_offset,
  ecal_secs_if.sink                         secs,
  ecal_cal_if.source                        cal,
  output ecal_pkg::operand_t                op,
  input  ecal_pkg::csub_res_t               res
);
  import ecal_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CLAMP, ST_DAY, ST_HOUR, ST_MIN, ST_BLK, ST_YEAR, ST_MON, ST_DONE
  } state_t;

  state_t                   state;
  logic [STEP_W-1:0]        k;
  logic signed [SUM_W-1:0]  sum;
  logic [T_W-1:0]           rem;
  logic [DAY_Q_W-1:0]       days;
  logic [HOUR_Q_W-1:0]      hour;
  logic [MIN_Q_W-1:0]       minute;
  logic [5:0]               second;
  logic [BLK_Q_W-1:0]       blk;
  logic [7:0]               year;
  logic [3:0]               month;
  logic [8:0]               doy;
  logic [4:0]               mday;
  logic [2:0]               wd;
  logic                     clamped;
  logic                     leap;
  logic [3:0]               wd_sum;
  logic [2:0]               wd_next;
  logic [T_W-1:0]           last_rem;

  logic                     out_valid;
  logic [5:0]               out_second;
  logic [5:0]               out_minute;
  logic [4:0]               out_hour;
  logic [4:0]               out_mday;
  logic [3:0]               out_month;
  logic [7:0]               out_year;
  logic [2:0]               out_wd;
  logic [8:0]               out_doy;
  logic                     out_clamped;

  assign secs.ready = (state == ST_IDLE);
  assign leap       = (year[1:0] == 2'b00);
  assign last_rem   = res.ge ? res.diff : rem;

  // advance the weekday by the weight of the day-count bit just set
  assign wd_sum  = {1'b0, wd} + {1'b0, POW2_MOD7[k]};
  assign wd_next = (wd_sum >= WEEK_DAYS) ? 3'(wd_sum - WEEK_DAYS) : wd_sum[2:0];

  always_comb begin
    op.a = rem;
    unique case (state)
      ST_DAY:  op.b = DAY_SECS << k;
      ST_HOUR: op.b = HOUR_SECS << k;
      ST_MIN:  op.b = MIN_SECS << k;
      ST_BLK:  op.b = BLOCK_DAYS << k;
      ST_YEAR: op.b = YEAR_DAYS + T_W'(leap);
      ST_MON:  op.b = T_W'(month_len(month, leap));
      default: op.b = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && cal.ready && state != ST_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (secs.valid) begin
            sum   <= SUM_W'(secs.epoch_seconds) + SUM_W'(zone_offset);
            state <= ST_CLAMP;
          end
        end
        ST_CLAMP: begin
          if (sum[SUM_W-1]) begin
            rem     <= '0;
            clamped <= 1'b1;
          end else if (sum[SUM_W-2:0] > {1'b0, LAST_SECOND}) begin
            rem     <= LAST_SECOND;
            clamped <= 1'b1;
          end else begin
            rem     <= sum[T_W-1:0];
            clamped <= 1'b0;
          end
          days   <= '0;
          hour   <= '0;
          minute <= '0;
          blk    <= '0;
          wd     <= EPOCH_WEEKDAY;
          k      <= STEP_W'(DAY_Q_W - 1);
          state  <= ST_DAY;
        end
        ST_DAY: begin
          if (res.ge) begin
            rem     <= res.diff;
            days[k] <= 1'b1;
            wd      <= wd_next;
          end
          if (k == '0) begin
            k     <= STEP_W'(HOUR_Q_W - 1);
            state <= ST_HOUR;
          end else begin
            k <= k - 1'b1;
          end
        end
        ST_HOUR: begin
          if (res.ge) begin
            rem           <= res.diff;
            hour[k[2:0]]  <= 1'b1;
          end
          if (k == '0) begin
            k     <= STEP_W'(MIN_Q_W - 1);
            state <= ST_MIN;
          end else begin
            k <= k - 1'b1;
          end
        end
        ST_MIN: begin
          if (res.ge) begin
            minute[k[2:0]] <= 1'b1;
          end
          if (k == '0) begin
            // what is left is the second; switch the remainder over to the day count
            second <= last_rem[5:0];
            rem    <= T_W'(days);
            k      <= STEP_W'(BLK_Q_W - 1);
            state  <= ST_BLK;
          end else begin
            rem <= last_rem;
            k   <= k - 1'b1;
          end
        end
        ST_BLK: begin
          if (res.ge) begin
            rem         <= res.diff;
            blk[k[2:0]] <= 1'b1;
          end
          if (k == '0) begin
            year  <= EPOCH_YEAR + {blk[BLK_Q_W-1:1], res.ge, 2'b00};
            state <= ST_YEAR;
          end else begin
            k <= k - 1'b1;
          end
        end
        ST_YEAR: begin
          if (res.ge) begin
            rem  <= res.diff;
            year <= year + 8'd1;
          end else begin
            doy   <= rem[8:0];
            month <= MONTH_JAN;
            state <= ST_MON;
          end
        end
        ST_MON: begin
          if (!res.ge || month == MONTH_DEC) begin
            mday  <= rem[4:0] + 5'd1;
            state <= ST_DONE;
          end else begin
            rem   <= res.diff;
            month <= month + 4'd1;
          end
        end
        ST_DONE: begin
          // hold until the output register is free
          if (!out_valid || cal.ready) begin
            out_valid   <= 1'b1;
            out_second  <= second;
            out_minute  <= minute;
            out_hour    <= hour;
            out_mday    <= mday;
            out_month   <= month;
            out_year    <= year;
            out_wd      <= wd;
            out_doy     <= doy;
            out_clamped <= clamped;
            state       <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign cal.valid           = out_valid;
  assign cal.second          = out_second;
  assign cal.minute          = out_minute;
  assign cal.hour            = out_hour;
  assign cal.day_of_month    = out_mday;
  assign cal.month           = out_month;
  assign cal.year_since_1900 = out_year;
  assign cal.weekday         = out_wd;
  assign cal.day_of_year     = out_doy;
  assign cal.clamped         = out_clamped;

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking bench for epoch_seconds_to_calendar: random and edge-case seconds
// through the valid/ready channels, zone offset swept across phases.
// Depends on ecal_pkg, ecal_ifs and the converter RTL.
module testbench;
  import ecal_pkg::*;

  localparam longint LAST_LOCAL  = 64'd4102444799;
  localparam int     QUIET_LIMIT = 6000;
  localparam int     SETTLE      = 64;
  localparam int     PHASE_ITEMS = 200;

  typedef struct packed {
    logic [5:0] second;
    logic [5:0] minute;
    logic [4:0] hour;
    logic [4:0] day_of_month;
    logic [3:0] month;
    logic [7:0] year_since_1900;
    logic [2:0] weekday;
    logic [8:0] day_of_year;
    logic       clamped;
  } calendar_t;

  class calendar_scoreboard;
    calendar_t                 due_dates[$];
    logic signed [ZONE_W-1:0]  zone;
    int                        mismatches;
    int                        strays;

    function new();
      zone       = ZONE_RESET;
      mismatches = 0;
      strays     = 0;
    endfunction

    // Broken-down local time for one input under the current zone offset
    function calendar_t local_calendar(logic signed [EPOCH_W-1:0] epoch_s);
      calendar_t c;
      longint    t;
      longint    days;
      longint    rem;
      longint    secs;
      int        year;
      int        mon;
      int        len;
      t = longint'(epoch_s) + longint'(zone);
      c.clamped = 1'b0;
      if (t < 0) begin
        t = 0;
        c.clamped = 1'b1;
      end else if (t > LAST_LOCAL) begin
        t = LAST_LOCAL;
        c.clamped = 1'b1;
      end
      days = t / 86400;
      secs = t % 86400;
      year = 1970 + 4 * int'(days / 1461);
      rem  = days % 1461;
      while (rem >= ((year % 4 == 0) ? 366 : 365)) begin
        rem  = rem - ((year % 4 == 0) ? 366 : 365);
        year = year + 1;
      end
      c.day_of_year = 9'(rem);
      for (mon = 0; mon < 11; mon++) begin
        if (mon == 1) len = (year % 4 == 0) ? 29 : 28;
        else if (mon == 3 || mon == 5 || mon == 8 || mon == 10) len = 30;
        else len = 31;
        if (rem < len) break;
        rem = rem - len;
      end
      c.day_of_month    = 5'(rem + 1);
      c.month           = 4'(mon);
      c.year_since_1900 = 8'(year - 1900);
      c.weekday         = 3'((days + 4) % 7);
      c.second          = 6'(secs % 60);
      c.minute          = 6'((secs / 60) % 60);
      c.hour            = 5'(secs / 3600);
      return c;
    endfunction

    function void note_seconds(logic signed [EPOCH_W-1:0] epoch_s);
      due_dates.push_back(local_calendar(epoch_s));
    endfunction

    function string show(calendar_t c);
      return $sformatf("%0d-%0d-%0d %0d:%0d:%0d wday %0d yday %0d clamped %0d",
                       c.year_since_1900, c.month, c.day_of_month, c.hour, c.minute,
                       c.second, c.weekday, c.day_of_year, c.clamped);
    endfunction

    function void check_result(calendar_t got);
      calendar_t exp;
      if (due_dates.size() == 0) begin
        strays++;
        if (strays + mismatches <= 10) $display("unexpected item: %s", show(got));
        return;
      end
      exp = due_dates.pop_front();
      if (got.second !== exp.second || got.minute !== exp.minute ||
          got.hour !== exp.hour || got.day_of_month !== exp.day_of_month ||
          got.month !== exp.month || got.year_since_1900 !== exp.year_since_1900 ||
          got.weekday !== exp.weekday || got.day_of_year !== exp.day_of_year ||
          got.clamped !== exp.clamped) begin
        mismatches++;
        if (strays + mismatches <= 10)
          $display("mismatch: expected %s, got %s", show(exp), show(got));
      end
    endfunction

    function int pending();
      return due_dates.size();
    endfunction
  endclass

  logic                     clk;
  logic                     rst;
  logic                     wr_en;
  logic signed [ZONE_W-1:0] wr_data;
  logic                     idle_on;
  logic                     hold_request;
  int                       quiet_cycles = 0;

  calendar_scoreboard sb = new();

  ecal_secs_if secs_ch();
  ecal_cal_if  cal_ch();

  epoch_seconds_to_calendar u_dut (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_data (wr_data),
    .secs    (secs_ch),
    .cal     (cal_ch)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one
  function automatic int gap_cycles();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 80) return $urandom_range(1, 3);
    if (pick < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 120);
  endfunction

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    cal_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (cal_ch.valid && cal_ch.ready)
        sb.check_result('{cal_ch.second, cal_ch.minute, cal_ch.hour, cal_ch.day_of_month,
                          cal_ch.month, cal_ch.year_since_1900, cal_ch.weekday,
                          cal_ch.day_of_year, cal_ch.clamped});
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        cal_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        cal_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        stall_left = gap_cycles() - 1;
        cal_ch.ready <= 1'b0;
      end else begin
        cal_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: nothing accepted for too long ends the run
  always @(posedge clk) begin
    if ((secs_ch.valid && secs_ch.ready) || (cal_ch.valid && cal_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("epoch_seconds_to_calendar regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic offer_seconds(input logic signed [EPOCH_W-1:0] epoch_s);
    secs_ch.valid         <= 1'b1;
    secs_ch.epoch_seconds <= epoch_s;
    @(posedge clk);
    while (!secs_ch.ready) @(posedge clk);
    sb.note_seconds(epoch_s);
  endtask

  // Offer the input that lands on local second t under the current offset
  task automatic offer_local(input longint t);
    longint e;
    e = t - longint'(sb.zone);
    offer_seconds(e[EPOCH_W-1:0]);
  endtask

  task automatic drain_results();
    secs_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_zone(input logic signed [ZONE_W-1:0] z);
    drain_results();
    wr_en   <= 1'b1;
    wr_data <= z;
    @(posedge clk);
    wr_en   <= 1'b0;
    sb.zone = z;
  endtask

  function automatic logic signed [EPOCH_W-1:0] pick_seconds();
    logic [EPOCH_W-1:0] raw;
    longint             t;
    longint             yr;
    longint             e;
    case ($urandom_range(0, 9))
      6: begin
        t = longint'($urandom_range(0, 47481)) * 86400;
        t = t + (($urandom_range(0, 1) == 1) ? $urandom_range(0, 2) : 86399 - $urandom_range(0, 2));
      end
      7: begin
        if ($urandom_range(0, 1) == 1) t = longint'($urandom_range(0, 200)) - 100;
        else t = LAST_LOCAL - 100 + $urandom_range(0, 200);
      end
      8: begin
        raw[31:0] = $urandom;
        raw[32]   = 1'($urandom_range(0, 1));
        return raw;
      end
      9: begin
        // year start, or the second before it
        yr = $urandom_range(0, 129);
        t  = (yr * 365 + (yr + 1) / 4) * 86400 - $urandom_range(0, 1);
      end
      default: t = longint'($urandom) % (LAST_LOCAL + 1);
    endcase
    e = t - longint'(sb.zone);
    return e[EPOCH_W-1:0];
  endfunction

  initial begin
    logic signed [ZONE_W-1:0] zones[8];
    int                       ph;
    int                       n;
    int                       fails;
    zones = '{ZONE_RESET, -17'sd43200, 17'sd50400, 17'sd0, 17'sh10000, 17'sd65535,
              17'sd0, ZONE_RESET};
    zones[6] = ZONE_W'($urandom);
    rst                   <= 1'b1;
    wr_en                 <= 1'b0;
    wr_data               <= '0;
    secs_ch.valid         <= 1'b0;
    secs_ch.epoch_seconds <= '0;
    idle_on      = 1'b1;
    hold_request = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Edge cases under the reset offset
    offer_seconds(33'h1_0000_0000);
    offer_seconds(33'h0_FFFF_FFFF);
    offer_seconds(33'h1_FFFF_FFFF);
    offer_seconds(33'h0_AAAA_AAAA);
    offer_seconds(33'h1_5555_5555);
    offer_seconds('0);
    offer_local(-1);
    offer_local(0);
    offer_local(86399);
    offer_local(31535999);
    offer_local(31536000);
    offer_local(68169600);
    offer_local(94694399);
    offer_local(951782400);
    offer_local(4102358400);
    offer_local(LAST_LOCAL);
    offer_local(LAST_LOCAL + 1);

    for (ph = 0; ph < 8; ph++) begin
      if (ph > 0) set_zone(zones[ph]);
      idle_on = (ph != 2 && ph != 5);
      offer_local(-1);
      offer_local(0);
      offer_local(LAST_LOCAL);
      offer_local(LAST_LOCAL + 1);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 3 && n == 50) hold_request = 1'b1;
        if (ph == 4 && n == 100) drain_results();
        if (idle_on && $urandom_range(0, 3) == 0 && !(ph == 3 && n >= 50 && n < 70)) begin
          secs_ch.valid <= 1'b0;
          repeat (gap_cycles()) @(posedge clk);
        end
        offer_seconds(pick_seconds());
      end
    end

    drain_results();
    fails = sb.mismatches + sb.strays + sb.pending();
    if (fails == 0) begin
      $display("epoch_seconds_to_calendar regression: pass");
    end else begin
      $display("epoch_seconds_to_calendar regression: fail");
    end
    $finish;
  end

endmodule

// ===== epoch_seconds_to_calendar.f =====
src/ecal_pkg.sv
src/ecal_ifs.sv
src/ecal_csub.sv
src/ecal_seq.sv
src/epoch_seconds_to_calendar.sv
tb/sv/testbench.sv
